@@ hdl/clamped_inverse_square_attraction_macros.svh @@
// Assertion helpers for the clamped attraction block.
`ifndef CLAMPED_INVERSE_SQUARE_ATTRACTION_MACROS_SVH
`define CLAMPED_INVERSE_SQUARE_ATTRACTION_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CISA_ASSERT_DIS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("clamped attraction check failed");

// Check a property on every clock edge, reset included.
`define CISA_ASSERT(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("clamped attraction check failed");

`endif

@@ hdl/cisa_pkg.sv @@
package cisa_pkg;

  localparam int POS_WIDTH_DEF = 18;
  localparam int FRAC_BITS_DEF = 8;
  localparam int MASS_W        = 16;
  localparam int DIST_W        = 18;
  localparam int OUT_W         = 24;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [DIST_W-1:0] MIN_DIST_RESET = DIST_W'(512);
  localparam logic [DIST_W-1:0] MAX_DIST_RESET = DIST_W'(1792);

  localparam logic [OUT_W-1:0] OUT_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_NEG_MAG = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [0:0] {
    REG_MIN_DISTANCE = 1'b0,
    REG_MAX_DISTANCE = 1'b1
  } cisa_reg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cisa_qstat_t;

endpackage

@@ hdl/cisa_front.sv @@
module cisa_front #(
  parameter int POS_WIDTH = cisa_pkg::POS_WIDTH_DEF,
  parameter int EW = 2 * cisa_pkg::MASS_W + 5 * (POS_WIDTH + 1) + 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [POS_WIDTH-1:0] attractor_x,
  input  logic signed [POS_WIDTH-1:0] attractor_y,
  input  logic signed [POS_WIDTH-1:0] attractor_z,
  input  logic [cisa_pkg::MASS_W-1:0] attractor_mass,
  input  logic signed [POS_WIDTH-1:0] particle_x,
  input  logic signed [POS_WIDTH-1:0] particle_y,
  input  logic signed [POS_WIDTH-1:0] particle_z,
  input  logic [cisa_pkg::MASS_W-1:0] particle_mass,
  input  logic                        full,
  output logic                        push,
  output logic [EW-1:0]               entry
);
  import cisa_pkg::*;

  localparam int DW = POS_WIDTH + 1;

  logic                 adv;
  logic                 f1_v, f2_v, f3_v;
  logic [DW-1:0]        d1 [3];
  logic [MASS_W-1:0]    ma1, mp1;
  logic [DW-1:0]        mag_c [3];
  logic [DW-1:0]        mag2 [3];
  logic [DW-1:0]        mag3 [3];
  logic [2*DW-1:0]      sq2 [3];
  logic [2:0]           sign2, sign3;
  logic [2*MASS_W-1:0]  prod2, prod3;
  logic                 zero2, zero3;
  logic [2*DW-1:0]      sum3;

  // hold the whole front while the queue cannot take the oldest item
  assign adv  = !(f3_v && full);
  assign busy = !adv;
  assign push = f3_v && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
    end else if (adv) begin
      f1_v <= start;
      f2_v <= f1_v;
      f3_v <= f2_v;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = d1[i][DW-1] ? (~d1[i] + DW'(1)) : d1[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1[0] <= {attractor_x[POS_WIDTH-1], attractor_x} - {particle_x[POS_WIDTH-1], particle_x};
      d1[1] <= {attractor_y[POS_WIDTH-1], attractor_y} - {particle_y[POS_WIDTH-1], particle_y};
      d1[2] <= {attractor_z[POS_WIDTH-1], attractor_z} - {particle_z[POS_WIDTH-1], particle_z};
      ma1   <= attractor_mass;
      mp1   <= particle_mass;
      for (int i = 0; i < 3; i++) begin
        mag2[i]  <= mag_c[i];
        sq2[i]   <= mag_c[i] * mag_c[i];
        sign2[i] <= d1[i][DW-1];
        mag3[i]  <= mag2[i];
      end
      prod2 <= ma1 * mp1;
      zero2 <= (d1[0] == '0) && (d1[1] == '0) && (d1[2] == '0);
      sum3  <= sq2[0] + sq2[1] + sq2[2];
      sign3 <= sign2;
      prod3 <= prod2;
      zero3 <= zero2;
    end
  end

  assign entry = {zero3, sign3, mag3[2], mag3[1], mag3[0], sum3, prod3};

endmodule

@@ hdl/cisa_queue.sv @@
module cisa_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cisa_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  pop,
  output logic                  valid,
  output logic [WIDTH-1:0]      rdata,
  output cisa_pkg::cisa_qstat_t stat
);
  import cisa_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp, rp;
  logic [CW-1:0]    count;
  logic             do_push, do_pop;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign valid      = !stat.empty;
  assign rdata      = mem[rp];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (do_pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

@@ hdl/cisa_sqrt.sv @@
module cisa_sqrt #(
  parameter int DW    = 19,
  parameter int SIDEW = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_v,
  input  logic [2*DW-1:0]  in_n,
  input  logic [SIDEW-1:0] in_side,
  output logic             out_v,
  output logic [DW-1:0]    out_root,
  output logic [SIDEW-1:0] out_side
);
  import cisa_pkg::*;

  localparam int NW = 2 * DW;
  localparam int RW = DW + 3;

  logic             st_v    [DW+1];
  logic [NW-1:0]    st_n    [DW+1];
  logic [RW-1:0]    st_rem  [DW+1];
  logic [DW-1:0]    st_root [DW+1];
  logic [SIDEW-1:0] st_side [DW+1];

  assign st_v[0]    = in_v;
  assign st_n[0]    = in_n;
  assign st_rem[0]  = '0;
  assign st_root[0] = '0;
  assign st_side[0] = in_side;

  // one result bit per stage: bring down two radicand bits, try 4*root+1
  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [RW-1:0] rn, t;
    logic          ge;
    always_comb begin
      rn = {st_rem[k][RW-3:0], st_n[k][NW-1:NW-2]};
      t  = (RW'(st_root[k]) << 2) | RW'(1);
      ge = (rn >= t);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k+1] <= 1'b0;
      end else begin
        st_v[k+1] <= st_v[k];
      end
    end
    always_ff @(posedge clk) begin
      st_n[k+1]    <= st_n[k] << 2;
      st_rem[k+1]  <= ge ? (rn - t) : rn;
      st_root[k+1] <= {st_root[k][DW-2:0], ge};
      st_side[k+1] <= st_side[k];
    end
  end

  assign out_v    = st_v[DW];
  assign out_root = st_root[DW];
  assign out_side = st_side[DW];

endmodule

@@ hdl/cisa_div.sv @@
module cisa_div #(
  parameter int DVW   = 19,
  parameter int QB    = 24,
  parameter int SIDEW = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_v,
  input  logic [DVW-1:0]   in_rem,
  input  logic [QB-1:0]    in_low,
  input  logic [DVW-1:0]   in_den,
  input  logic [SIDEW-1:0] in_side,
  output logic             out_v,
  output logic [QB-1:0]    out_q,
  output logic [SIDEW-1:0] out_side
);
  import cisa_pkg::*;

  logic             st_v    [QB+1];
  logic [DVW-1:0]   st_rem  [QB+1];
  logic [QB-1:0]    st_low  [QB+1];
  logic [DVW-1:0]   st_den  [QB+1];
  logic [SIDEW-1:0] st_side [QB+1];

  assign st_v[0]    = in_v;
  assign st_rem[0]  = in_rem;
  assign st_low[0]  = in_low;
  assign st_den[0]  = in_den;
  assign st_side[0] = in_side;

  // restoring division: shift in one dividend bit, shift out one quotient bit
  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DVW:0] r, rd;
    logic         ge;
    always_comb begin
      r  = {st_rem[k], st_low[k][QB-1]};
      ge = (r >= {1'b0, st_den[k]});
      rd = r - {1'b0, st_den[k]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k+1] <= 1'b0;
      end else begin
        st_v[k+1] <= st_v[k];
      end
    end
    always_ff @(posedge clk) begin
      st_rem[k+1]  <= ge ? rd[DVW-1:0] : r[DVW-1:0];
      st_low[k+1]  <= {st_low[k][QB-2:0], ge};
      st_den[k+1]  <= st_den[k];
      st_side[k+1] <= st_side[k];
    end
  end

  assign out_v    = st_v[QB];
  assign out_q    = st_low[QB];
  assign out_side = st_side[QB];

endmodule

@@ hdl/cisa_back.sv @@
module cisa_back #(
  parameter int DW        = cisa_pkg::POS_WIDTH_DEF + 1,
  parameter int FRAC_BITS = cisa_pkg::FRAC_BITS_DEF,
  parameter int EW        = 2 * cisa_pkg::MASS_W + 5 * DW + 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_v,
  input  logic [EW-1:0]               entry,
  input  logic [cisa_pkg::DIST_W-1:0] min_distance,
  input  logic [cisa_pkg::DIST_W-1:0] max_distance,
  output logic                        done,
  output logic [cisa_pkg::OUT_W-1:0]  force_x,
  output logic [cisa_pkg::OUT_W-1:0]  force_y,
  output logic [cisa_pkg::OUT_W-1:0]  force_z,
  output logic                        saturated
);
  import cisa_pkg::*;

  localparam int PRW   = 2 * MASS_W;
  localparam int SW    = PRW + FRAC_BITS;
  localparam int SL    = SW / 2;
  localparam int SH    = SW - SL;
  localparam int PW    = DW + SW;
  localparam int CW    = (DW > DIST_W) ? DW : DIST_W;
  localparam int HW    = PW - OUT_W;
  localparam int DEN_W = 2 * DIST_W;
  localparam int QSW   = 4 + 3 * DW + PRW;
  localparam int DSW   = DW + 4 + 3 * DW;

  // sqrt
  logic             q_v;
  logic [DW-1:0]    q_root;
  logic [QSW-1:0]   q_side;

  cisa_sqrt #(.DW(DW), .SIDEW(QSW)) u_sqrt (
    .clk(clk), .rst(rst), .in_v(in_v),
    .in_n(entry[PRW +: 2*DW]),
    .in_side({entry[EW-1 -: 4 + 3*DW], entry[PRW-1:0]}),
    .out_v(q_v), .out_root(q_root), .out_side(q_side)
  );

  // clamp
  logic              c_v;
  logic [DIST_W-1:0] c_dist, dist_c;
  logic [CW-1:0]     len_w;
  logic [DW-1:0]     c_len;
  logic [QSW-1:0]    c_side;

  always_comb begin
    len_w = CW'(q_root);
    if (len_w < CW'(min_distance)) begin
      dist_c = min_distance;
    end else if (len_w > CW'(max_distance)) begin
      dist_c = max_distance;
    end else begin
      dist_c = len_w[DIST_W-1:0];
    end
    if (dist_c == '0) begin
      dist_c = DIST_W'(1);
    end
  end

  // den and num
  logic             m_v;
  logic [DEN_W-1:0] m_den;
  logic [SW-1:0]    m_num;
  logic [DW-1:0]    m_len;
  logic [3+3*DW:0]  m_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
      m_v <= 1'b0;
    end else begin
      c_v <= q_v;
      m_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    c_dist  <= dist_c;
    c_len   <= q_root;
    c_side  <= q_side;
    m_den   <= c_dist * c_dist;
    m_num   <= SW'(c_side[PRW-1:0]) << FRAC_BITS;
    m_len   <= c_len;
    m_flags <= c_side[QSW-1:PRW];
  end

  // strength
  logic           s_v;
  logic [SW-1:0]  s_str;
  logic [DSW-1:0] s_side;

  cisa_div #(.DVW(DEN_W), .QB(SW), .SIDEW(DSW)) u_div_str (
    .clk(clk), .rst(rst), .in_v(m_v), .in_rem('0), .in_low(m_num),
    .in_den(m_den), .in_side({m_len, m_flags}),
    .out_v(s_v), .out_q(s_str), .out_side(s_side)
  );

  // split product of magnitude and strength
  logic             p1_v, p2_v, o_v;
  logic [DW+SL-1:0] p1_lo [3];
  logic [DW+SH-1:0] p1_hi [3];
  logic [PW-1:0]    p2_n [3];
  logic [DW-1:0]    p1_len, p2_len, o_len;
  logic [3:0]       p1_zs, p2_zs, o_zs;
  logic [HW-1:0]    hi_c [3];
  logic [2:0]       ovf_c;
  logic [2:0]       o_ovf;
  logic [DW-1:0]    o_rem [3];
  logic [OUT_W-1:0] o_low [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      o_v  <= 1'b0;
    end else begin
      p1_v <= s_v;
      p2_v <= p1_v;
      o_v  <= p2_v;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hi_c[i]  = p2_n[i][PW-1:OUT_W];
      ovf_c[i] = (hi_c[i] >= HW'(p2_len));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p1_lo[i] <= s_side[i*DW +: DW] * s_str[SL-1:0];
      p1_hi[i] <= s_side[i*DW +: DW] * s_str[SW-1:SL];
      p2_n[i]  <= PW'(p1_lo[i]) + (PW'(p1_hi[i]) << SL);
      o_rem[i] <= ovf_c[i] ? '0 : hi_c[i][DW-1:0];
      o_low[i] <= p2_n[i][OUT_W-1:0];
    end
    p1_len <= s_side[DSW-1 -: DW];
    p1_zs  <= s_side[3*DW +: 4];
    p2_len <= p1_len;
    p2_zs  <= p1_zs;
    o_len  <= p2_len;
    o_zs   <= p2_zs;
    o_ovf  <= ovf_c;
  end

  // divide each component by the length
  logic             f_v [3];
  logic [OUT_W-1:0] f_q [3];
  logic [4:0]       f_side0;
  logic             f_side1, f_side2;

  cisa_div #(.DVW(DW), .QB(OUT_W), .SIDEW(5)) u_div_x (
    .clk(clk), .rst(rst), .in_v(o_v), .in_rem(o_rem[0]), .in_low(o_low[0]),
    .in_den(o_len), .in_side({o_zs, o_ovf[0]}),
    .out_v(f_v[0]), .out_q(f_q[0]), .out_side(f_side0)
  );
  cisa_div #(.DVW(DW), .QB(OUT_W), .SIDEW(1)) u_div_y (
    .clk(clk), .rst(rst), .in_v(o_v), .in_rem(o_rem[1]), .in_low(o_low[1]),
    .in_den(o_len), .in_side(o_ovf[1]),
    .out_v(f_v[1]), .out_q(f_q[1]), .out_side(f_side1)
  );
  cisa_div #(.DVW(DW), .QB(OUT_W), .SIDEW(1)) u_div_z (
    .clk(clk), .rst(rst), .in_v(o_v), .in_rem(o_rem[2]), .in_low(o_low[2]),
    .in_den(o_len), .in_side(o_ovf[2]),
    .out_v(f_v[2]), .out_q(f_q[2]), .out_side(f_side2)
  );

  // saturate and sign
  logic [2:0]       f_ovf, f_sign, sat_c;
  logic             f_zero;
  logic [OUT_W-1:0] res_c [3];

  assign f_ovf  = {f_side2, f_side1, f_side0[0]};
  assign f_sign = f_side0[3:1];
  assign f_zero = f_side0[4];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (f_sign[i]) begin
        sat_c[i] = f_ovf[i] || (f_q[i] > OUT_NEG_MAG);
        res_c[i] = sat_c[i] ? OUT_NEG_MAG : (~f_q[i] + OUT_W'(1));
      end else begin
        sat_c[i] = f_ovf[i] || (f_q[i] > OUT_POS_MAX);
        res_c[i] = sat_c[i] ? OUT_POS_MAX : f_q[i];
      end
      if (f_zero) begin
        sat_c[i] = 1'b0;
        res_c[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_v[0] && f_v[1] && f_v[2];
    end
  end

  always_ff @(posedge clk) begin
    force_x   <= res_c[0];
    force_y   <= res_c[1];
    force_z   <= res_c[2];
    saturated <= |sat_c;
  end

endmodule

@@ hdl/clamped_inverse_square_attraction.sv @@
// Clamped inverse-square attraction between one attractor and one particle.
//
// Input channel: raise start with both positions (signed Q10.8) and both
// masses (unsigned Q8.8); the transaction is taken at a rising edge where
// start is high and busy is low. Output channel: done is high for exactly
// one cycle with force_x/y/z (signed Q16.8) and saturated; the receiver
// cannot hold results off, so the pipeline never stalls on that side.
// Configuration: wr_en with wr_index (0 min_distance, 1 max_distance) and
// wr_data writes one clamp register at the edge; write only while idle.
//
// Throughput: one transaction per cycle while busy is low. The back end holds
// the square-root pipeline (POS_WIDTH+1 stages), the strength divider
// (32+FRAC_BITS stages) and the three component dividers (24 stages).
// A three-stage front feeds a two-entry queue that the back drains every
// cycle; busy rises only if that queue is full.
// Reset clears all valid bits and the queue and loads the clamp registers
// with 2.0 and 7.0; transactions in flight are dropped.
`include "clamped_inverse_square_attraction_macros.svh"

module clamped_inverse_square_attraction #(
  parameter int POS_WIDTH = cisa_pkg::POS_WIDTH_DEF,
  parameter int FRAC_BITS = cisa_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        wr_en,
  input  logic [0:0]                  wr_index,
  input  logic [cisa_pkg::DIST_W-1:0] wr_data,
  input  logic signed [POS_WIDTH-1:0] attractor_x,
  input  logic signed [POS_WIDTH-1:0] attractor_y,
  input  logic signed [POS_WIDTH-1:0] attractor_z,
  input  logic [cisa_pkg::MASS_W-1:0] attractor_mass,
  input  logic signed [POS_WIDTH-1:0] particle_x,
  input  logic signed [POS_WIDTH-1:0] particle_y,
  input  logic signed [POS_WIDTH-1:0] particle_z,
  input  logic [cisa_pkg::MASS_W-1:0] particle_mass,
  output logic                        done,
  output logic signed [cisa_pkg::OUT_W-1:0] force_x,
  output logic signed [cisa_pkg::OUT_W-1:0] force_y,
  output logic signed [cisa_pkg::OUT_W-1:0] force_z,
  output logic                        saturated
);
  import cisa_pkg::*;

  localparam int DW = POS_WIDTH + 1;
  localparam int EW = 2 * MASS_W + 5 * DW + 4;

  // clamp registers
  logic [DIST_W-1:0] min_distance, max_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= MIN_DIST_RESET;
      max_distance <= MAX_DIST_RESET;
    end else if (wr_en) begin
      unique case (cisa_reg_t'(wr_index))
        REG_MIN_DISTANCE: min_distance <= wr_data;
        REG_MAX_DISTANCE: max_distance <= wr_data;
        default: ;
      endcase
    end
  end

  // front: take the transaction, form the difference vector, squares and
  // mass product, and flag coincident points
  logic          push;
  logic [EW-1:0] f_entry;
  cisa_qstat_t   q_stat;

  cisa_front #(.POS_WIDTH(POS_WIDTH), .EW(EW)) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .attractor_x(attractor_x), .attractor_y(attractor_y),
    .attractor_z(attractor_z), .attractor_mass(attractor_mass),
    .particle_x(particle_x), .particle_y(particle_y),
    .particle_z(particle_z), .particle_mass(particle_mass),
    .full(q_stat.full), .push(push), .entry(f_entry)
  );

  // queue between the two halves; the back pops whenever an entry waits
  logic          q_v;
  logic [EW-1:0] q_entry;

  cisa_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(f_entry),
    .pop(q_v), .valid(q_v), .rdata(q_entry), .stat(q_stat)
  );

  // back: sqrt, clamp, strength, per-component divide and saturate
  cisa_back #(.DW(DW), .FRAC_BITS(FRAC_BITS), .EW(EW)) u_back (
    .clk(clk), .rst(rst), .in_v(q_v), .entry(q_entry),
    .min_distance(min_distance), .max_distance(max_distance),
    .done(done), .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .saturated(saturated)
  );

  // some component sits at a range limit
  logic lim_hit;
  assign lim_hit = (force_x == OUT_POS_MAX) || (force_x == OUT_NEG_MAG) ||
                   (force_y == OUT_POS_MAX) || (force_y == OUT_NEG_MAG) ||
                   (force_z == OUT_POS_MAX) || (force_z == OUT_NEG_MAG);

  // busy means the queue is full
  `CISA_ASSERT_DIS(a_busy_full, clk, rst, busy |-> q_stat.full)
  // a clipped result carries a component at a range limit
  `CISA_ASSERT_DIS(a_sat_limit, clk, rst, (done && saturated) |-> lim_hit)
  // reset drops every transaction in flight
  `CISA_ASSERT(a_rst_quiet, clk, rst |=> !done)

endmodule
